// ===== rtl/core/plce_pkg.sv =====
package plce_pkg;

	// Default list depth
	localparam int CAPACITY_DEF = 64;

	// Request codes
	localparam logic [2:0] REQ_INS_HEAD = 3'd0;
	localparam logic [2:0] REQ_INS_TAIL = 3'd1;
	localparam logic [2:0] REQ_INS_AT   = 3'd2;
	localparam logic [2:0] REQ_REM_HEAD = 3'd3;
	localparam logic [2:0] REQ_REM_TAIL = 3'd4;
	localparam logic [2:0] REQ_REM_AT   = 3'd5;
	localparam logic [2:0] REQ_READ_AT  = 3'd6;
	localparam logic [2:0] REQ_SIZE     = 3'd7;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] position;
		logic [7:0] value;
	} plce_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_value;
		logic [6:0] item_count;
	} plce_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_TAKE_RD,
		S_TAKE_CAP,
		S_REM_RD,
		S_REM_WR,
		S_FIN
	} plce_state_t;

	typedef enum logic [1:0] {
		K_INS,
		K_REM,
		K_READ,
		K_SIZE
	} plce_kind_t;

	// Read address source
	typedef enum logic [1:0] {
		RA_PREV,
		RA_IDX,
		RA_NEXT
	} plce_raddr_t;

	// Controller -> datapath
	typedef struct packed {
		logic        load_req;
		logic        check;
		logic        rd_en;
		plce_raddr_t rd_sel;
		logic        wr_move;
		logic        wr_val;
		logic        ptr_dec;
		logic        ptr_inc;
		logic        cap_rd;
		logic        cnt_inc;
		logic        cnt_dec;
		logic        out_load;
	} plce_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		plce_kind_t kind;
		logic       bad;
		logic       ins_direct;
		logic       ins_last;
		logic       rem_done_cap;
		logic       rem_done_wr;
		logic       out_busy;
	} plce_sts_t;

endpackage

// ===== rtl/core/positional_char_list_engine.sv =====
// Channel   Dir  Handshake             Beat
// req       in   req_valid/req_stall   req_type, position, value
// rsp       out  rsp_valid/rsp_stall   status, read_value, item_count
//
// One request at a time. A size or failed request goes from the check to the result;
// a read visits the store; insert and remove shift m elements (up to CAPACITY-1).
// The shift walks the one-read, one-write store one element per read/write pair.
// Reset clears the element count and the control; store contents need no clearing.
// A result held by rsp_stall stays in its register; the next request is taken
// and worked on meanwhile, and waits to finish until that register frees up.
module positional_char_list_engine #(
	parameter int CAPACITY = plce_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  plce_pkg::plce_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output plce_pkg::plce_rsp_t rsp
);

	import plce_pkg::*;

	plce_cmd_t cmd;
	plce_sts_t sts;

	plce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	plce_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/plce_ram.sv =====
module plce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/plce_ctrl.sv =====
module plce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  plce_pkg::plce_sts_t sts,
	output plce_pkg::plce_cmd_t cmd
);

	import plce_pkg::*;

	plce_state_t state_q;
	plce_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.bad || sts.kind == K_SIZE) begin
					state_d = S_FIN;
				end else if (sts.kind == K_INS) begin
					state_d = sts.ins_direct ? S_INS_PUT : S_INS_RD;
				end else begin
					state_d = S_TAKE_RD;
				end
			end
			S_INS_RD:   state_d = S_INS_WR;
			S_INS_WR: begin
				state_d = sts.ins_last ? S_INS_PUT : S_INS_RD;
			end
			S_INS_PUT:  state_d = S_FIN;
			S_TAKE_RD:  state_d = S_TAKE_CAP;
			S_TAKE_CAP: begin
				if (sts.kind == K_READ || sts.rem_done_cap) state_d = S_FIN;
				else state_d = S_REM_RD;
			end
			S_REM_RD:   state_d = S_REM_WR;
			S_REM_WR: begin
				state_d = sts.rem_done_wr ? S_FIN : S_REM_RD;
			end
			S_FIN: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RA_IDX;
		req_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall    = 1'b0;
				cmd.load_req = req_valid;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
			end
			S_INS_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_PREV;
			end
			S_INS_WR: begin
				cmd.wr_move = 1'b1;
				cmd.ptr_dec = 1'b1;
			end
			S_INS_PUT: begin
				cmd.wr_val  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_TAKE_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_IDX;
			end
			S_TAKE_CAP: begin
				cmd.cap_rd  = 1'b1;
				cmd.cnt_dec = (sts.kind == K_REM) && sts.rem_done_cap;
			end
			S_REM_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_NEXT;
			end
			S_REM_WR: begin
				cmd.wr_move = 1'b1;
				cmd.ptr_inc = 1'b1;
				cmd.cnt_dec = sts.rem_done_wr;
			end
			S_FIN: begin
				cmd.out_load = !sts.out_busy;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/plce_dp.sv =====
module plce_dp #(
	parameter int CAPACITY = plce_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plce_pkg::plce_req_t req,
	input  plce_pkg::plce_cmd_t cmd,
	output plce_pkg::plce_sts_t sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output plce_pkg::plce_rsp_t rsp
);

	import plce_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

	plce_req_t req_q;
	plce_rsp_t rsp_q;
	logic      rsp_valid_q;

	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] ptr_q;
	logic [1:0]    status_q;
	logic [7:0]    rd_q;

	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] tgt_x;
	logic [CMPW-1:0] tgt_idx;
	logic [1:0]      chk_status;
	plce_kind_t      kind;

	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [7:0]    wdata;

	assign cnt_x   = CMPW'(count_q);
	assign pos_x   = CMPW'(req_q.position);
	assign tgt_idx = tgt_x - CMPW'(1);

	// Request decode: kind and one-based target position
	always_comb begin
		case (req_q.req_type) inside
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: kind = K_INS;
			REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_AT: kind = K_REM;
			REQ_READ_AT:                            kind = K_READ;
			default:                                kind = K_SIZE;
		endcase
		case (req_q.req_type) inside
			REQ_INS_HEAD, REQ_REM_HEAD: tgt_x = CMPW'(1);
			REQ_INS_TAIL:               tgt_x = cnt_x + CMPW'(1);
			REQ_REM_TAIL:               tgt_x = cnt_x;
			default:                    tgt_x = pos_x;
		endcase
	end

	// Bound and capacity check
	always_comb begin
		chk_status = ST_OK;
		case (kind)
			K_INS: begin
				if (tgt_x == '0 || tgt_x > cnt_x + CMPW'(1)) chk_status = ST_FAIL;
				else if (cnt_x >= CMPW'(CAPACITY)) chk_status = ST_FULL;
			end
			K_REM, K_READ: begin
				if (cnt_x == '0 || tgt_x == '0 || tgt_x > cnt_x) chk_status = ST_FAIL;
			end
			default: chk_status = ST_OK;
		endcase
	end

	// Status toward the controller
	always_comb begin
		sts.kind         = kind;
		sts.bad          = (chk_status != ST_OK);
		sts.ins_direct   = (tgt_x == cnt_x + CMPW'(1));
		sts.ins_last     = ((ptr_q - AW'(1)) == idx_q);
		sts.rem_done_cap = (CMPW'(ptr_q) + CMPW'(1) >= cnt_x);
		sts.rem_done_wr  = (CMPW'(ptr_q) + CMPW'(2) >= cnt_x);
		sts.out_busy     = rsp_valid_q && rsp_stall;
	end

	// Read address select
	always_comb begin
		case (cmd.rd_sel)
			RA_PREV: raddr = ptr_q - AW'(1);
			RA_NEXT: raddr = ptr_q + AW'(1);
			default: raddr = idx_q;
		endcase
	end

	// Writes always land at the walk pointer
	assign wdata = cmd.wr_val ? req_q.value : rdata;

	plce_ram #(
		.WIDTH (8),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_move || cmd.wr_val),
		.waddr (ptr_q),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Request, target, walk pointer, captured read and result fields
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
			rd_q  <= '0;
		end
		if (cmd.check) begin
			status_q <= chk_status;
			idx_q    <= tgt_idx[AW-1:0];
			ptr_q    <= (kind == K_INS) ? AW'(count_q) : tgt_idx[AW-1:0];
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (cmd.cap_rd) begin
			rd_q <= rdata;
		end
		if (cmd.out_load) begin
			rsp_q.status     <= status_q;
			rsp_q.read_value <= rd_q;
			rsp_q.item_count <= 7'(count_q);
		end
	end

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_put_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (ptr_q == idx_q))
		else $error("insert write not at target slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result overwritten while stalled");

	a_inc_dec_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec))
		else $error("count grown and shrunk together");
`endif

endmodule

// ===== dv/plce_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow copy of the byte list, and compares
// every response beat with the oldest one owed.
module plce_checker #(
	parameter int CAPACITY = plce_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  plce_pkg::plce_req_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  plce_pkg::plce_rsp_t rsp,
	output int                  fail_cnt,
	output int                  pending,
	output int                  list_len,
	output int                  rsp_cnt,
	output int                  full_cnt
);

	import plce_pkg::*;

	logic [7:0] cells [CAPACITY];
	plce_rsp_t  owed_rsp [$];

	// Apply one request to the shadow list and return the response it earns
	function automatic plce_rsp_t apply_list_op(plce_req_t r);
		plce_rsp_t res;
		int slot;
		res = '0;
		res.status = ST_OK;
		case (r.req_type)
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
				if (r.req_type == REQ_INS_HEAD)
					slot = 1;
				else if (r.req_type == REQ_INS_TAIL)
					slot = list_len + 1;
				else
					slot = int'(r.position);
				// bad position wins over full
				if (slot < 1 || slot > list_len + 1) begin
					res.status = ST_FAIL;
				end else if (list_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = list_len; i >= slot; i--)
						cells[i] = cells[i - 1];
					cells[slot - 1] = r.value;
					list_len++;
				end
			end
			REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_AT: begin
				if (r.req_type == REQ_REM_HEAD)
					slot = 1;
				else if (r.req_type == REQ_REM_TAIL)
					slot = list_len;
				else
					slot = int'(r.position);
				if (list_len == 0 || slot < 1 || slot > list_len) begin
					res.status = ST_FAIL;
				end else begin
					res.read_value = cells[slot - 1];
					for (int i = slot - 1; i < list_len - 1; i++)
						cells[i] = cells[i + 1];
					list_len--;
				end
			end
			REQ_READ_AT: begin
				slot = int'(r.position);
				if (list_len == 0 || slot < 1 || slot > list_len)
					res.status = ST_FAIL;
				else
					res.read_value = cells[slot - 1];
			end
			default: ;
		endcase
		res.item_count = 7'(list_len);
		return res;
	endfunction

	// Record owed responses on request beats, check response beats
	always @(posedge clk or negedge arst_n) begin
		plce_rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			owed_rsp.delete();
			pending = 0;
		end else begin
			if (req_valid && !req_stall)
				owed_rsp.push_back(apply_list_op(req));
			if (rsp_valid && !rsp_stall) begin
				rsp_cnt++;
				if (owed_rsp.size() == 0) begin
					$error("response beat with nothing owed: status %0d read_value %0d item_count %0d",
						rsp.status, rsp.read_value, rsp.item_count);
					fail_cnt++;
				end else begin
					want = owed_rsp.pop_front();
					if (want.status == ST_FULL)
						full_cnt++;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_cnt++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							rsp.read_value);
						fail_cnt++;
					end
					if (rsp.item_count !== want.item_count) begin
						$error("item_count: expected %0d, got %0d", want.item_count,
							rsp.item_count);
						fail_cnt++;
					end
				end
			end
			pending = owed_rsp.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import plce_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// longest shift moves CAPACITY-1 elements; leave margin
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 200;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	plce_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	plce_rsp_t rsp;

	int fail_cnt;
	int pending;
	int list_len;
	int rsp_cnt;
	int full_cnt;
	int sent_cnt;
	int cycle_cnt;
	bit quiet;

	positional_char_list_engine #(.CAPACITY(CAPACITY)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	plce_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fail_cnt  (fail_cnt),
		.pending   (pending),
		.list_len  (list_len),
		.rsp_cnt   (rsp_cnt),
		.full_cnt  (full_cnt)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random request; positional ones mostly aimed at the live range
	function automatic plce_req_t make_item(op_mix_t mix);
		plce_req_t r;
		int roll;
		int ins_pct;
		int rem_pct;
		int hi;
		r.value    = 8'($urandom_range(0, 255));
		r.position = 8'($urandom_range(0, 255));
		case (mix)
			MIX_FILL: begin
				ins_pct = 80;
				rem_pct = 10;
			end
			MIX_DRAIN: begin
				ins_pct = 10;
				rem_pct = 80;
			end
			default: begin
				ins_pct = 40;
				rem_pct = 40;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) begin
			case ($urandom_range(0, 2))
				0:       r.req_type = REQ_INS_HEAD;
				1:       r.req_type = REQ_INS_TAIL;
				default: r.req_type = REQ_INS_AT;
			endcase
		end else if (roll < ins_pct + rem_pct) begin
			case ($urandom_range(0, 2))
				0:       r.req_type = REQ_REM_HEAD;
				1:       r.req_type = REQ_REM_TAIL;
				default: r.req_type = REQ_REM_AT;
			endcase
		end else begin
			r.req_type = $urandom_range(0, 1) ? REQ_READ_AT : REQ_SIZE;
		end
		if (r.req_type inside {REQ_INS_AT, REQ_REM_AT, REQ_READ_AT}) begin
			hi = (r.req_type == REQ_INS_AT) ? list_len + 1 : list_len;
			roll = $urandom_range(0, 99);
			if (hi > 0 && roll < 70)
				r.position = 8'($urandom_range(1, hi));
			else if (hi > 0 && roll < 85)
				r.position = 8'($urandom_range(0, 1) ? 1 : hi);
			else if (roll < 92)
				r.position = 8'((hi < 255) ? hi + 1 : 0);
			// otherwise the position stays fully random
		end
		return r;
	endfunction

	// Idle for a random gap, return at the falling edge where the next beat starts
	task automatic start_beat();
		int gap;
		logic [18:0] junk;
		gap = pick_gap();
		if (gap > 0) begin
			junk = 19'($urandom);
			@(negedge clk);
			req_valid <= 1'b0;
			req       <= junk;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
	endtask

	// Present one beat and hold it until taken
	task automatic offer(input plce_req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sent_cnt++;
	endtask

	task automatic send_fixed(input logic [2:0] kind, input int pos, input int val);
		plce_req_t r;
		r.req_type = kind;
		r.position = 8'(pos);
		r.value    = 8'(val);
		start_beat();
		offer(r);
	endtask

	// Response side: random stalls, plus one long hold-off to back up the input
	initial begin : rsp_side
		int len;
		bit held;
		held      = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sent_cnt >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				len = pick_gap();
				rsp_stall <= (len != 0);
				if (len > 1)
					repeat (len - 1) @(negedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		op_mix_t plan [8];
		int      plan_len [8];
		plan      = '{MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL,
			MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_DRAIN};
		plan_len  = '{110, 110, 90, 110, 70, 110, 90, 100};
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		quiet     = 1'b0;
		sent_cnt  = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list: size with ignored fields at their max, then requests that fail
		send_fixed(REQ_SIZE, 255, 255);
		send_fixed(REQ_REM_HEAD, 0, 0);
		send_fixed(REQ_REM_TAIL, 0, 0);
		send_fixed(REQ_REM_AT, 1, 0);
		send_fixed(REQ_READ_AT, 0, 0);
		send_fixed(REQ_INS_AT, 0, 7);
		send_fixed(REQ_INS_AT, 2, 7);
		// build 0x00 0x3c 0xff 0xa5 0x5a
		send_fixed(REQ_INS_AT, 1, 255);
		send_fixed(REQ_INS_HEAD, 255, 0);
		send_fixed(REQ_INS_TAIL, 0, 'ha5);
		send_fixed(REQ_INS_AT, 4, 'h5a);
		send_fixed(REQ_INS_AT, 2, 'h3c);
		// reads at the ends, just past and far past
		send_fixed(REQ_READ_AT, 5, 0);
		send_fixed(REQ_READ_AT, 1, 0);
		send_fixed(REQ_READ_AT, 6, 0);
		send_fixed(REQ_READ_AT, 255, 0);
		// removes, then size and an out-of-range insert
		send_fixed(REQ_REM_AT, 0, 0);
		send_fixed(REQ_REM_AT, 6, 0);
		send_fixed(REQ_REM_AT, 3, 255);
		send_fixed(REQ_REM_HEAD, 0, 0);
		send_fixed(REQ_REM_TAIL, 0, 0);
		send_fixed(REQ_SIZE, 0, 0);
		send_fixed(REQ_INS_AT, 255, 1);

		// random phases: fill to full, drain to empty, mixed traffic
		foreach (plan[ph]) begin
			quiet = (ph == 2);
			repeat (plan_len[ph]) begin
				start_beat();
				offer(make_item(plan[ph]));
			end
		end
		quiet = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d list requests, checked %0d responses.", sent_cnt, rsp_cnt);
		$display("%0d inserts met a full list; %0d field mismatches.", full_cnt, fail_cnt);
		if (fail_cnt == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/plce_pkg.sv
rtl/core/plce_ram.sv
rtl/core/plce_ctrl.sv
rtl/core/plce_dp.sv
rtl/core/positional_char_list_engine.sv
dv/plce_checker.sv
dv/testbench.sv
